// ===== hdl/hasd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hasd_pkg
// Shared widths, register indexes, status codes and control structs for the
// Hall angle and speed decoder.
// ----------------------------------------------------------------------------
package hasd_pkg;

  localparam int SEQ_LEN    = 6;
  localparam int CODE_W     = 3;
  localparam int SLOT_W     = 3;
  localparam int TIME_W     = 32;
  localparam int ANGLE_W    = 16;
  localparam int SPEED_W    = 28;
  localparam int PP_W       = 7;
  localparam int DEN_W      = TIME_W + PP_W;
  localparam int SEQ_W      = SEQ_LEN * CODE_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;
  localparam int CNT_W      = $clog2(SPEED_W + 1);

  // 60 s * 1e6 us / 6 Hall code changes per electrical turn, scaled by 16
  localparam logic [SPEED_W-1:0] SPEED_NUM = SPEED_W'(160000000);

  localparam logic [CFG_IDX_W-1:0] REG_CODE_SEQ   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE0     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_COUNT = CFG_IDX_W'(7);

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  localparam logic [PP_W-1:0] PAIR_COUNT_RESET = PP_W'(1);

  typedef struct packed {
    logic [SEQ_W-1:0]                code_seq;
    logic [SEQ_LEN-1:0][ANGLE_W-1:0] angle;
    logic [PP_W-1:0]                 pair_count;
  } cfg_regs_t;

  typedef struct packed {
    logic             start;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [SPEED_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== hdl/hasd_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hasd_in_if
// Hall sample channel: sensor code and microsecond timestamp.
// ----------------------------------------------------------------------------
interface hasd_in_if;
  logic                        valid;
  logic                        ready;
  logic [hasd_pkg::CODE_W-1:0] sensor_code;
  logic [hasd_pkg::TIME_W-1:0] sample_time_us;

  modport source (output valid, output sensor_code, output sample_time_us, input ready);
  modport sink (input valid, input sensor_code, input sample_time_us, output ready);
endinterface

// ===== hdl/hasd_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hasd_out_if
// Result channel: status, stored electrical angle and stored speed.
// ----------------------------------------------------------------------------
interface hasd_out_if;
  logic                         valid;
  logic                         ready;
  logic                         status_code;
  logic [hasd_pkg::ANGLE_W-1:0] electrical_angle;
  logic [hasd_pkg::SPEED_W-1:0] speed_sixteenths_rpm;

  modport source (
    output valid, output status_code, output electrical_angle,
    output speed_sixteenths_rpm, input ready
  );
  modport sink (
    input valid, input status_code, input electrical_angle,
    input speed_sixteenths_rpm, output ready
  );
endinterface

// ===== hdl/hasd_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hasd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface hasd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [hasd_pkg::CFG_IDX_W-1:0]  index;
  logic [hasd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/hasd_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hasd_div
// Restoring serial divider: constant speed numerator over a 39-bit
// denominator, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hasd_div (
  input  logic               clk,
  input  logic               rst,
  input  hasd_pkg::div_req_t req,
  output hasd_pkg::div_rsp_t rsp
);

  logic [hasd_pkg::SPEED_W-1:0] rem;
  logic [hasd_pkg::SPEED_W-1:0] rem_next;
  logic [hasd_pkg::SPEED_W-1:0] quot;
  logic [hasd_pkg::DEN_W-1:0]   den;
  logic [hasd_pkg::CNT_W-1:0]   cnt;
  logic                         busy;
  logic                         done;
  logic [hasd_pkg::SPEED_W:0]   trial;
  logic                         fits;

  // quot shifts the numerator out at the top and quotient bits in at the bottom
  assign trial = {rem, quot[hasd_pkg::SPEED_W-1]};
  assign fits  = {{(hasd_pkg::DEN_W - hasd_pkg::SPEED_W - 1){1'b0}}, trial} >= den;

  always_comb begin
    if (fits) begin
      rem_next = hasd_pkg::SPEED_W'(trial - den[hasd_pkg::SPEED_W:0]);
    end else begin
      rem_next = trial[hasd_pkg::SPEED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= hasd_pkg::CNT_W'(hasd_pkg::SPEED_W);
        rem  <= '0;
        quot <= hasd_pkg::SPEED_NUM;
        den  <= req.den;
      end else if (busy) begin
        rem  <= rem_next;
        quot <= {quot[hasd_pkg::SPEED_W-2:0], fits};
        cnt  <= cnt - hasd_pkg::CNT_W'(1);
        if (cnt == hasd_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

// ===== hdl/hasd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hasd_ctrl
// Sequencer and decoder state: sequence lookup, angle and edge-time update,
// denominator product and hand-off to the serial divider.
// ----------------------------------------------------------------------------
module hasd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  hasd_pkg::cfg_regs_t cfg_regs,
  hasd_in_if.sink             hall,
  hasd_out_if.source          result,
  output hasd_pkg::div_req_t  div_req,
  input  hasd_pkg::div_rsp_t  div_rsp
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EVAL  = 6'b000010,
    S_MUL   = 6'b000100,
    S_START = 6'b001000,
    S_DIV   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t                        state;
  logic [hasd_pkg::CODE_W-1:0]   code;
  logic [hasd_pkg::TIME_W-1:0]   sample_time;
  logic [hasd_pkg::TIME_W-1:0]   delta;
  logic [hasd_pkg::DEN_W-1:0]    den;
  logic [hasd_pkg::ANGLE_W-1:0]  angle_now;
  logic [hasd_pkg::SPEED_W-1:0]  speed_now;
  logic [hasd_pkg::TIME_W-1:0]   last_edge_time;
  logic [hasd_pkg::CODE_W-1:0]   last_code;
  logic                          status;
  logic                          hit;
  logic [hasd_pkg::SLOT_W-1:0]   slot;

  // walk down so the lowest matching entry wins
  always_comb begin
    hit  = 1'b0;
    slot = '0;
    for (int k = hasd_pkg::SEQ_LEN - 1; k >= 0; k--) begin
      if (cfg_regs.code_seq[k*hasd_pkg::CODE_W +: hasd_pkg::CODE_W] == code) begin
        hit  = 1'b1;
        slot = hasd_pkg::SLOT_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      angle_now      <= '0;
      speed_now      <= '0;
      last_edge_time <= '0;
      last_code      <= '0;
      status         <= hasd_pkg::STATUS_OK;
    end else begin
      case (state)
        S_IDLE: begin
          if (hall.valid) begin
            code        <= hall.sensor_code;
            sample_time <= hall.sample_time_us;
            state       <= S_EVAL;
          end
        end
        S_EVAL: begin
          state <= S_OUT;
          if (cfg_regs.pair_count != '0 && hit) begin
            status    <= hasd_pkg::STATUS_OK;
            angle_now <= cfg_regs.angle[slot];
            if (code != last_code) begin
              last_edge_time <= sample_time;
              last_code      <= code;
              if (last_edge_time != '0 && sample_time > last_edge_time) begin
                delta <= sample_time - last_edge_time;
                state <= S_MUL;
              end
            end
          end else begin
            status <= hasd_pkg::STATUS_INVALID;
          end
        end
        S_MUL: begin
          den   <= hasd_pkg::DEN_W'(delta) * hasd_pkg::DEN_W'(cfg_regs.pair_count);
          state <= S_START;
        end
        S_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            speed_now <= div_rsp.quot;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (result.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign div_req.start = (state == S_START);
  assign div_req.den   = den;

  assign hall.ready                  = (state == S_IDLE);
  assign result.valid                = (state == S_OUT);
  assign result.status_code          = status;
  assign result.electrical_angle     = angle_now;
  assign result.speed_sixteenths_rpm = speed_now;

endmodule

// ===== hdl/hall_angle_speed_decoder.sv =====
// Sequence: an accepted sample beat goes through lookup to a valid result when no
// speed is computed, and through lookup, product and the 28-step divider when it is.
// One item at a time: the next sample beat is taken the cycle after the result beat.
// Reset: sync, active high; stored angle, speed, edge time and code clear to
// zero, registers clear to zero except pole pairs, which resets to one.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hall_angle_speed_decoder
// Hall code to electrical angle and mechanical speed, with a configuration
// register file and a serial divider for the speed quotient.
// ----------------------------------------------------------------------------
module hall_angle_speed_decoder (
  input  logic       clk,
  input  logic       rst,
  hasd_in_if.sink    hall,
  hasd_out_if.source result,
  hasd_cfg_if.sink   cfg
);

  hasd_pkg::cfg_regs_t cfg_regs;
  hasd_pkg::div_req_t  div_req;
  hasd_pkg::div_rsp_t  div_rsp;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.code_seq   <= '0;
      cfg_regs.angle      <= '0;
      cfg_regs.pair_count <= hasd_pkg::PAIR_COUNT_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == hasd_pkg::REG_CODE_SEQ) begin
        cfg_regs.code_seq <= cfg.data[hasd_pkg::SEQ_W-1:0];
      end
      for (int k = 0; k < hasd_pkg::SEQ_LEN; k++) begin
        if (cfg.index == hasd_pkg::REG_ANGLE0 + hasd_pkg::CFG_IDX_W'(k)) begin
          cfg_regs.angle[k] <= cfg.data[hasd_pkg::ANGLE_W-1:0];
        end
      end
      if (cfg.index == hasd_pkg::REG_PAIR_COUNT) begin
        cfg_regs.pair_count <= cfg.data[hasd_pkg::PP_W-1:0];
      end
    end
  end

  hasd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_regs (cfg_regs),
    .hall     (hall),
    .result   (result),
    .div_req  (div_req),
    .div_rsp  (div_rsp)
  );

  hasd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

endmodule

// ===== hdl/hasd_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hasd_chk
// Port-level checks for the decoder: one item in flight, one result per item.
// ----------------------------------------------------------------------------
module hasd_chk (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         status_code,
  input logic [hasd_pkg::ANGLE_W-1:0] electrical_angle,
  input logic [hasd_pkg::SPEED_W-1:0] speed_sixteenths_rpm
);

  // a sample beat closes the input: ready is low right after it
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a sample beat");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while a result is pending");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status_code)
      && $stable(electrical_angle) && $stable(speed_sixteenths_rpm))
    else $error("stalled result beat changed");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> !out_valid)
    else $error("second result beat without a new sample");

endmodule

bind hall_angle_speed_decoder hasd_chk u_hasd_chk (
  .clk                  (clk),
  .rst                  (rst),
  .in_valid             (hall.valid),
  .in_ready             (hall.ready),
  .out_valid            (result.valid),
  .out_ready            (result.ready),
  .status_code          (result.status_code),
  .electrical_angle     (result.electrical_angle),
  .speed_sixteenths_rpm (result.speed_sixteenths_rpm)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Hall angle and speed decoder. Samples go in
// through a bursty driver and results are taken by a stalling receiver. Each
// accepted sample is run through a local decoder model. The model's stored
// angle, speed, edge time and code give the result expected for that sample,
// which is compared field by field with the next result beat. Phases reload
// the register file: sequences, angles and pole pairs, extremes included.
// ----------------------------------------------------------------------------
module testbench;

  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          DRAIN_WAIT  = 40;
  localparam int          PHASES      = 7;
  // Hall sequence 1-3-2-6-4-5, entry 0 in the low bits
  localparam logic [hasd_pkg::SEQ_W-1:0] HALL_SEQ_STD = 18'b101_100_110_010_011_001;

  typedef struct packed {
    logic [hasd_pkg::CODE_W-1:0] code;
    logic [hasd_pkg::TIME_W-1:0] stamp;
  } hall_sample_t;

  typedef struct packed {
    logic                         status;
    logic [hasd_pkg::ANGLE_W-1:0] angle;
    logic [hasd_pkg::SPEED_W-1:0] speed;
  } reading_t;

  logic clk = 1'b0;
  logic rst;

  hasd_in_if  hall_bus ();
  hasd_out_if result_bus ();
  hasd_cfg_if cfg_bus ();

  hall_angle_speed_decoder dut (
    .clk    (clk),
    .rst    (rst),
    .hall   (hall_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  hall_sample_t hall_samples[$];
  reading_t     angle_speed_q[$];
  hall_sample_t next_sample;
  reading_t     want;

  // Decoder model: register mirror and stored state
  hasd_pkg::cfg_regs_t          cfg_mirror;
  logic [hasd_pkg::ANGLE_W-1:0] rotor_angle;
  logic [hasd_pkg::SPEED_W-1:0] rotor_speed;
  logic [hasd_pkg::TIME_W-1:0]  edge_stamp;
  logic [hasd_pkg::CODE_W-1:0]  prev_code;

  int unsigned cycle_count = 0;
  int          fail_count  = 0;
  logic        sample_taken = 1'b0;
  int          burst_left   = 0;
  int          gap_left     = 0;
  int          stall_left   = 0;

  function automatic reading_t decode_hall(input logic [hasd_pkg::CODE_W-1:0] code,
                                           input logic [hasd_pkg::TIME_W-1:0] stamp);
    reading_t        r;
    int              slot;
    longint unsigned span;
    slot = -1;
    // Scan downward so the lowest matching entry wins
    for (int k = hasd_pkg::SEQ_LEN - 1; k >= 0; k--) begin
      if (cfg_mirror.code_seq[hasd_pkg::CODE_W*k +: hasd_pkg::CODE_W] == code) slot = k;
    end
    r.status = hasd_pkg::STATUS_INVALID;
    if (cfg_mirror.pair_count != '0 && slot >= 0) begin
      r.status    = hasd_pkg::STATUS_OK;
      rotor_angle = cfg_mirror.angle[slot];
      if (code != prev_code) begin
        if (edge_stamp != '0 && stamp > edge_stamp) begin
          span        = 64'(stamp - edge_stamp) * 64'(cfg_mirror.pair_count);
          rotor_speed = hasd_pkg::SPEED_W'(64'(hasd_pkg::SPEED_NUM) / span);
        end
        edge_stamp = stamp;
        prev_code  = code;
      end
    end
    r.angle = rotor_angle;
    r.speed = rotor_speed;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Sample channel handshakes, prediction and result checking
  always @(posedge clk) begin
    sample_taken <= !rst && hall_bus.valid && hall_bus.ready;
    if (!rst) begin
      if (hall_bus.valid && hall_bus.ready)
        angle_speed_q.push_back(decode_hall(hall_bus.sensor_code, hall_bus.sample_time_us));
      if (result_bus.valid && result_bus.ready) begin
        if (angle_speed_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual status %0d angle %0d speed %0d",
                   $time, result_bus.status_code, result_bus.electrical_angle,
                   result_bus.speed_sixteenths_rpm);
          fail_count++;
        end else begin
          want = angle_speed_q.pop_front();
          check_field("status_code", 64'(want.status), 64'(result_bus.status_code));
          check_field("electrical_angle", 64'(want.angle), 64'(result_bus.electrical_angle));
          check_field("speed_sixteenths_rpm", 64'(want.speed),
                      64'(result_bus.speed_sixteenths_rpm));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Sample driver: bursts of beats separated by random gaps
  always @(negedge clk) begin
    if (rst) begin
      hall_bus.valid <= 1'b0;
    end else if (!hall_bus.valid || sample_taken) begin
      if (gap_left > 0) begin
        hall_bus.valid <= 1'b0;
        gap_left--;
      end else if (hall_samples.size() != 0) begin
        next_sample = hall_samples.pop_front();
        hall_bus.valid          <= 1'b1;
        hall_bus.sensor_code    <= next_sample.code;
        hall_bus.sample_time_us <= next_sample.stamp;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end else begin
          burst_left--;
        end
      end else begin
        hall_bus.valid <= 1'b0;
      end
    end
  end

  // Result receiver: the stall style rotates with bits 9:8 of the cycle count
  always @(negedge clk) begin
    if (rst) begin
      result_bus.ready <= 1'b0;
    end else begin
      case (cycle_count[9:8])
        2'd0: result_bus.ready <= 1'b1;
        2'd1: begin
          if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 40);
          if (stall_left > 0) begin
            result_bus.ready <= 1'b0;
            stall_left--;
          end else begin
            result_bus.ready <= 1'b1;
          end
        end
        2'd2: result_bus.ready <= cycle_count[0];
        default: result_bus.ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  task automatic write_reg(input logic [hasd_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [hasd_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      hasd_pkg::REG_CODE_SEQ:   cfg_mirror.code_seq   = val[hasd_pkg::SEQ_W-1:0];
      hasd_pkg::REG_PAIR_COUNT: cfg_mirror.pair_count = val[hasd_pkg::PP_W-1:0];
      default: cfg_mirror.angle[idx - hasd_pkg::REG_ANGLE0] = val[hasd_pkg::ANGLE_W-1:0];
    endcase
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Write every register; bits above each field's width carry noise
  task automatic load_config(input logic [hasd_pkg::SEQ_W-1:0] seq,
                             input logic [hasd_pkg::PP_W-1:0] pp,
                             input bit extreme_angles);
    logic [hasd_pkg::ANGLE_W-1:0] ang;
    write_reg(hasd_pkg::REG_CODE_SEQ, seq);
    for (int k = 0; k < hasd_pkg::SEQ_LEN; k++) begin
      ang = extreme_angles ? ((k % 2 == 1) ? 16'hFFFF : 16'h0000)
                           : hasd_pkg::ANGLE_W'($urandom);
      write_reg(hasd_pkg::REG_ANGLE0 + hasd_pkg::CFG_IDX_W'(k), {2'($urandom), ang});
    end
    write_reg(hasd_pkg::REG_PAIR_COUNT, {11'($urandom), pp});
  endtask

  function automatic logic [hasd_pkg::SEQ_W-1:0] random_sequence(input bit distinct);
    logic [hasd_pkg::CODE_W-1:0] pool[8];
    logic [hasd_pkg::CODE_W-1:0] tmp;
    logic [hasd_pkg::SEQ_W-1:0]  seq;
    int                          j;
    if (!distinct) return hasd_pkg::SEQ_W'($urandom);
    for (int k = 0; k < 8; k++) pool[k] = hasd_pkg::CODE_W'(k);
    for (int k = 7; k > 0; k--) begin
      j       = $urandom_range(0, k);
      tmp     = pool[k];
      pool[k] = pool[j];
      pool[j] = tmp;
    end
    for (int k = 0; k < hasd_pkg::SEQ_LEN; k++)
      seq[hasd_pkg::CODE_W*k +: hasd_pkg::CODE_W] = pool[k];
    return seq;
  endfunction

  task automatic add_sample(input logic [hasd_pkg::CODE_W-1:0] code,
                            input logic [hasd_pkg::TIME_W-1:0] stamp);
    hall_samples.push_back('{code: code, stamp: stamp});
  endtask

  // Mostly a rotor turning through the sequence, with repeats, stale or zero
  // timestamps, direction changes and a little noise mixed in
  task automatic queue_rotation(input int count);
    logic [hasd_pkg::TIME_W-1:0] stamp;
    logic [hasd_pkg::TIME_W-1:0] span;
    int                          pos;
    int                          pick;
    bit                          forward;
    stamp   = $urandom;
    pos     = $urandom_range(0, hasd_pkg::SEQ_LEN - 1);
    forward = 1'($urandom_range(0, 1));
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) forward = !forward;
      case ($urandom_range(0, 3))
        0:       span = $urandom_range(1, 16);
        1:       span = $urandom_range(17, 5000);
        2:       span = $urandom_range(5001, 2000000);
        default: span = $urandom;
      endcase
      if (pick < 95 && !(pick >= 80 && pick < 87))
        pos = forward ? (pos + 1) % hasd_pkg::SEQ_LEN
                      : (pos + hasd_pkg::SEQ_LEN - 1) % hasd_pkg::SEQ_LEN;
      if (pick < 80) stamp = stamp + span;
      else if (pick < 87) stamp = stamp + $urandom_range(0, 50);
      else if (pick < 92) stamp = stamp - $urandom_range(0, 2000);
      else if (pick < 95) stamp = '0;
      if (pick < 95)
        add_sample(cfg_mirror.code_seq[hasd_pkg::CODE_W*pos +: hasd_pkg::CODE_W], stamp);
      else add_sample(hasd_pkg::CODE_W'($urandom_range(0, 7)), hasd_pkg::TIME_W'($urandom));
    end
  endtask

  task automatic drain();
    while (hall_samples.size() != 0 || hall_bus.valid || angle_speed_q.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    rst                     = 1'b1;
    hall_bus.valid          = 1'b0;
    hall_bus.sensor_code    = '0;
    hall_bus.sample_time_us = '0;
    result_bus.ready        = 1'b0;
    cfg_bus.valid           = 1'b0;
    cfg_bus.index           = '0;
    cfg_bus.data            = '0;
    cfg_mirror.code_seq     = '0;
    cfg_mirror.angle        = '0;
    cfg_mirror.pair_count   = hasd_pkg::PAIR_COUNT_RESET;
    rotor_angle             = '0;
    rotor_speed             = '0;
    edge_stamp              = '0;
    prev_code               = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Reset registers: every entry holds code zero
    add_sample(3'd0, 32'd5);
    add_sample(3'd3, 32'd9);
    add_sample(3'd7, 32'hFFFF_FFFF);
    drain();

    load_config(HALL_SEQ_STD, 7'd1, 1'b1);
    add_sample(3'd1, 32'd0);            // edge recorded at time zero
    add_sample(3'd3, 32'd100);          // no speed after an edge at zero
    add_sample(3'd3, 32'd150);          // repeated code
    add_sample(3'd2, 32'd101);          // one microsecond: top speed
    add_sample(3'd6, 32'd50);           // timestamp went back
    add_sample(3'd4, 32'd50);           // timestamp unchanged
    add_sample(3'd0, 32'd60);           // unknown codes
    add_sample(3'd7, 32'd60);
    add_sample(3'd5, 32'hFFFF_FFFF);    // huge interval: speed rounds to zero
    add_sample(3'd1, 32'hFFFF_FFFF);
    add_sample(3'd3, 32'd0);
    add_sample(3'd2, 32'd5000);
    drain();

    load_config(HALL_SEQ_STD, 7'd0, 1'b0);
    add_sample(3'd1, 32'd10);           // zero pole pairs reject everything
    add_sample(3'd3, 32'd20);
    drain();

    load_config(HALL_SEQ_STD, 7'd127, 1'b1);
    add_sample(3'd1, 32'd1000);
    add_sample(3'd3, 32'd1001);
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: load_config(HALL_SEQ_STD, 7'd1, 1'b0);
        1: load_config(random_sequence(1'b1), 7'd64, 1'b1);
        2: load_config(random_sequence(1'b0), 7'd127, 1'b0);
        3: load_config(random_sequence(1'b1), 7'd0, 1'b0);
        4: load_config(random_sequence(1'b1), hasd_pkg::PP_W'($urandom_range(1, 127)), 1'b0);
        5: load_config(random_sequence(1'b1), hasd_pkg::PP_W'($urandom_range(2, 8)), 1'b1);
        default: load_config(random_sequence(1'b0), 7'd1, 1'b0);
      endcase
      queue_rotation((phase == 3) ? 30 : 210);
      drain();
    end

    repeat (DRAIN_WAIT) @(negedge clk);
    if (fail_count == 0 && angle_speed_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
